// File: rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the bank switch mapper
// Word layouts, bus function codes, register indexes and bank helpers.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned RAM_DEPTH_DEF = 8192;

  localparam logic [5:0] PRG_BANK_COUNT_RST = 6'd32;

  // configuration register indexes (word address bits above the byte offset)
  localparam logic REG_PRG_BANK_COUNT = 1'b0;

  typedef enum logic [2:0] {
    FN_CPU_RD  = 3'd0,
    FN_CPU_WR  = 3'd1,
    FN_PPU_RD  = 3'd2,
    FN_PPU_WR  = 3'd3,
    FN_TICK    = 3'd4,
    FN_IRQ_ACK = 3'd5
  } func_e;

  // CPU address regions, by addr[15:13] (RGN_CHR is a PPU region)
  localparam logic [2:0] RGN_WRAM    = 3'b011;
  localparam logic [2:0] RGN_BANK    = 3'b100;
  localparam logic [2:0] RGN_MIRROR  = 3'b101;
  localparam logic [2:0] RGN_IRQ_CFG = 3'b110;
  localparam logic [2:0] RGN_IRQ_EN  = 3'b111;
  localparam logic [2:0] RGN_CHR     = 3'b000;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] addr;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [18:0] mapped_addr;
    logic        ram_access;
    logic [7:0]  read_data;
    logic        irq_active;
    logic        mirror_horizontal;
  } out_word_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [12:0] addr;
    logic [7:0]  wdata;
  } ram_req_t;

  // 8 KB bank number to ROM offset
  function automatic logic [18:0] bank8k(input logic [5:0] bank);
    bank8k = {bank, 13'h0000};
  endfunction

  // bank number of the second-last 8 KB window, modulo 64
  function automatic logic [5:0] second_last_bank(input logic [5:0] count);
    second_last_bank = {count[4:0], 1'b0} + 6'd62;
  endfunction

  function automatic logic [5:0] last_bank(input logic [5:0] count);
    last_bank = {count[4:0], 1'b0} + 6'd63;
  endfunction

endpackage

// File: rtl/bank_switch_mapper_irq_core.sv
// Each accepted word's result is registered and shown in the next cycle.
// Throughput: one word per cycle unless in_stall_o holds; the result register
//   drains while the next word is taken, and the work RAM's single port serves
//   one word per cycle. Reset: all mapper registers return to power-on values
//   at once; the work RAM is then cleared to zero, one byte a cycle, with input
//   stall held high. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// bank_switch_mapper_irq_core: cartridge bank mapper with scanline IRQ
// Translates CPU/PPU bus words to ROM offsets, serves the work RAM and runs
// the scanline IRQ counter. Bank count register on an APB-style port.
// ----------------------------------------------------------------------------
module bank_switch_mapper_irq_core #(
  parameter int unsigned RAM_DEPTH = bsm_pkg::RAM_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bsm_pkg::in_word_t  in_word_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bsm_pkg::out_word_t out_word_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bsm_pkg::*;

  logic      acc;
  logic      cfg_we;
  logic      ram_busy;
  logic      ram_rd;
  logic [7:0] ram_rdata;
  logic [5:0] prg_bank_count;
  ram_req_t  ram_req;
  out_word_t res_d;
  out_word_t res_q;
  logic      rd_sel_q;
  logic      out_valid_q;

  // Hold input while the RAM clears or while a finished word waits unread.
  assign in_stall_o = ram_busy || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;

  // Register write completes on the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_PRG_BANK_COUNT);

  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == REG_PRG_BANK_COUNT) begin
      prdata = {26'h0, prg_bank_count};
    end
  end

  bsm_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .in_word_i        (in_word_i),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (pwdata[5:0]),
    .res_o            (res_d),
    .ram_rd_o         (ram_rd),
    .ram_req_o        (ram_req),
    .prg_bank_count_o (prg_bank_count)
  );

  bsm_wram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_wram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  // Result register: load on accept, drop valid once the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q    <= res_d;
      rd_sel_q <= ram_rd;
    end
  end

  // The RAM read data register only reloads on an accepted RAM read, so it
  // holds alongside the result register during a stall.
  always_comb begin
    out_word_o = res_q;
    out_word_o.read_data = rd_sel_q ? ram_rdata : 8'h00;
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bsm_wram.sv
// ----------------------------------------------------------------------------
// bsm_wram: work RAM
// Single-port byte memory with registered read data and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module bsm_wram #(
  parameter int unsigned RAM_DEPTH = bsm_pkg::RAM_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsm_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o,
  output logic              busy_o
);
  import bsm_pkg::*;

  localparam int unsigned IDX_W = $clog2(RAM_DEPTH);
  localparam logic [15:0] DEPTH_X4 = 16'(RAM_DEPTH * 4);
  localparam logic [15:0] DEPTH_X2 = 16'(RAM_DEPTH * 2);
  localparam logic [15:0] DEPTH_X1 = 16'(RAM_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RAM_DEPTH - 1);

  logic [7:0]       mem [RAM_DEPTH];
  logic [7:0]       rdata_q;
  logic             busy_q;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [15:0]      r0, r1, r2, r3;
  logic [IDX_W-1:0] idx;

  // fold the 13-bit offset into the depth (offset is below 8x depth)
  always_comb begin
    r0 = {3'b000, req_i.addr};
    r1 = (r0 >= DEPTH_X4) ? r0 - DEPTH_X4 : r0;
    r2 = (r1 >= DEPTH_X2) ? r1 - DEPTH_X2 : r1;
    r3 = (r2 >= DEPTH_X1) ? r2 - DEPTH_X1 : r2;
    idx = r3[IDX_W-1:0];
  end

  assign clr_idx_d = clr_idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_d;
      if (clr_idx_q == IDX_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_idx_q] <= 8'h00;
    end else if (req_i.wr) begin
      mem[idx] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[idx];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// File: rtl/bsm_regs.sv
// ----------------------------------------------------------------------------
// bsm_regs: mapper registers and address translation
// Bank, mirroring and IRQ state, precomputed bank bases, per-word result.
// ----------------------------------------------------------------------------
module bsm_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  bsm_pkg::in_word_t  in_word_i,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_data_i,
  output bsm_pkg::out_word_t res_o,
  output logic               ram_rd_o,
  output bsm_pkg::ram_req_t  ram_req_o,
  output logic [5:0]         prg_bank_count_o
);
  import bsm_pkg::*;

  logic [5:0]  count_q, count_d;
  logic [2:0]  bank_sel_q, bank_sel_d;
  logic        prg_swap_q, prg_swap_d;
  logic        chr_inv_q, chr_inv_d;
  logic [7:0]  bank_regs_q [8];
  logic [7:0]  bank_regs_d [8];
  logic [17:0] chr_base_q [8];
  logic [17:0] chr_base_d [8];
  logic [17:0] chr_calc [8];
  logic [18:0] prg_base_q [4];
  logic [18:0] prg_base_d [4];
  logic [18:0] prg_calc [4];
  logic        mirror_q, mirror_d;
  logic [7:0]  irq_cnt_q, irq_cnt_d;
  logic [7:0]  irq_latch_q, irq_latch_d;
  logic        irq_on_q, irq_on_d;
  logic        irq_pend_q, irq_pend_d;
  logic        refresh;

  logic [2:0]  fn;
  logic [15:0] a;
  logic [7:0]  wd;
  logic        odd;
  logic [2:0]  rgn;

  assign fn  = in_word_i.func;
  assign a   = in_word_i.addr;
  assign wd  = in_word_i.write_data;
  assign odd = a[0];
  assign rgn = a[15:13];

  always_comb begin
    count_d     = count_q;
    bank_sel_d  = bank_sel_q;
    prg_swap_d  = prg_swap_q;
    chr_inv_d   = chr_inv_q;
    bank_regs_d = bank_regs_q;
    mirror_d    = mirror_q;
    irq_cnt_d   = irq_cnt_q;
    irq_latch_d = irq_latch_q;
    irq_on_d    = irq_on_q;
    irq_pend_d  = irq_pend_q;
    refresh     = 1'b0;
    res_o       = '0;
    ram_rd_o    = 1'b0;
    ram_req_o   = '0;
    ram_req_o.addr  = a[12:0];
    ram_req_o.wdata = wd;

    if (acc_i) begin
      case (func_e'(fn))
        FN_CPU_RD: begin
          if (rgn == RGN_WRAM) begin
            res_o.hit        = 1'b1;
            res_o.ram_access = 1'b1;
            ram_rd_o         = 1'b1;
            ram_req_o.rd     = 1'b1;
          end else if (a[15]) begin
            res_o.hit         = 1'b1;
            res_o.mapped_addr = prg_base_q[a[14:13]] + {6'b0, a[12:0]};
          end
        end
        FN_CPU_WR: begin
          case (rgn)
            RGN_WRAM: begin
              res_o.hit        = 1'b1;
              res_o.ram_access = 1'b1;
              ram_req_o.wr     = 1'b1;
            end
            RGN_BANK: begin
              if (!odd) begin
                bank_sel_d = wd[2:0];
                prg_swap_d = wd[6];
                chr_inv_d  = wd[7];
              end else begin
                bank_regs_d[bank_sel_q] = wd;
              end
              refresh = 1'b1;
            end
            RGN_MIRROR: begin
              if (!odd) begin
                mirror_d = wd[0];
              end
            end
            RGN_IRQ_CFG: begin
              if (!odd) begin
                irq_latch_d = wd;
              end else begin
                irq_cnt_d = 8'h00;
              end
            end
            RGN_IRQ_EN: begin
              if (!odd) begin
                irq_on_d   = 1'b0;
                irq_pend_d = 1'b0;
              end else begin
                irq_on_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        FN_PPU_RD: begin
          if (rgn == RGN_CHR) begin
            res_o.hit         = 1'b1;
            res_o.mapped_addr = {1'b0, chr_base_q[a[12:10]]} + {9'b0, a[9:0]};
          end
        end
        FN_TICK: begin
          irq_cnt_d = (irq_cnt_q == 8'h00) ? irq_latch_q : irq_cnt_q - 8'd1;
          if (irq_cnt_d == 8'h00 && irq_on_q) begin
            irq_pend_d = 1'b1;
          end
        end
        FN_IRQ_ACK: begin
          irq_pend_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we_i) begin
      count_d = cfg_data_i;
    end

    res_o.irq_active        = irq_pend_d;
    res_o.mirror_horizontal = mirror_d;
  end

  // bank bases from the updated register values
  always_comb begin
    logic [18:0] sl;
    logic [18:0] sw;
    sl = bank8k(second_last_bank(count_d));
    sw = bank8k(bank_regs_d[6][5:0]);
    prg_calc[0] = prg_swap_d ? sl : sw;
    prg_calc[2] = prg_swap_d ? sw : sl;
    prg_calc[1] = bank8k(bank_regs_d[7][5:0]);
    prg_calc[3] = bank8k(last_bank(count_d));
    for (int i = 0; i < 4; i++) begin
      chr_calc[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      chr_calc[i] = '0;
    end
    if (chr_inv_d) begin
      chr_calc[4] = {bank_regs_d[0][7:1], 1'b0, 10'h000};
      chr_calc[5] = {bank_regs_d[0][7:1], 1'b1, 10'h000};
      chr_calc[6] = {bank_regs_d[1][7:1], 1'b0, 10'h000};
      chr_calc[7] = {bank_regs_d[1][7:1], 1'b1, 10'h000};
      for (int i = 0; i < 4; i++) begin
        chr_calc[i] = {bank_regs_d[2 + i], 10'h000};
      end
    end else begin
      chr_calc[0] = {bank_regs_d[0][7:1], 1'b0, 10'h000};
      chr_calc[1] = {bank_regs_d[0][7:1], 1'b1, 10'h000};
      chr_calc[2] = {bank_regs_d[1][7:1], 1'b0, 10'h000};
      chr_calc[3] = {bank_regs_d[1][7:1], 1'b1, 10'h000};
      for (int i = 0; i < 4; i++) begin
        chr_calc[4 + i] = {bank_regs_d[2 + i], 10'h000};
      end
    end
    chr_base_d = refresh ? chr_calc : chr_base_q;
    prg_base_d = (refresh || cfg_we_i) ? prg_calc : prg_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= PRG_BANK_COUNT_RST;
      bank_sel_q    <= 3'd0;
      prg_swap_q    <= 1'b0;
      chr_inv_q     <= 1'b0;
      mirror_q      <= 1'b1;
      irq_cnt_q     <= 8'h00;
      irq_latch_q   <= 8'h00;
      irq_on_q      <= 1'b0;
      irq_pend_q    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_regs_q[i] <= 8'h00;
        chr_base_q[i]  <= 18'h00000;
      end
      prg_base_q[0] <= 19'h00000;
      prg_base_q[1] <= bank8k(6'd1);
      prg_base_q[2] <= bank8k(second_last_bank(PRG_BANK_COUNT_RST));
      prg_base_q[3] <= bank8k(last_bank(PRG_BANK_COUNT_RST));
    end else begin
      count_q     <= count_d;
      bank_sel_q  <= bank_sel_d;
      prg_swap_q  <= prg_swap_d;
      chr_inv_q   <= chr_inv_d;
      bank_regs_q <= bank_regs_d;
      chr_base_q  <= chr_base_d;
      prg_base_q  <= prg_base_d;
      mirror_q    <= mirror_d;
      irq_cnt_q   <= irq_cnt_d;
      irq_latch_q <= irq_latch_d;
      irq_on_q    <= irq_on_d;
      irq_pend_q  <= irq_pend_d;
    end
  end

  assign prg_bank_count_o = count_q;

endmodule
